// File: rtl/mva_pkg.sv
// ----------------------------------------------------------------------------
// mva_pkg
// Types and constants shared by the max vertex angle block.
// ----------------------------------------------------------------------------
`default_nettype none
package mva_pkg;
	localparam int CoordW = 24;
	localparam int AngW = 24;
	localparam int DirW = 32;
	localparam int CordW = 60;

	typedef struct packed {
		logic signed [CoordW-1:0] coord_x;
		logic signed [CoordW-1:0] coord_y;
		logic is_last;
	} mva_in_t;

	typedef struct packed {
		logic [AngW-1:0] max_angle;
		logic points_dropped;
	} mva_out_t;

	typedef enum logic [3:0] {
		ST_LOAD, ST_RDI, ST_WAITI, ST_RDJ, ST_WAITJ, ST_CSTART, ST_CORD, ST_RDJ2,
		ST_RDK, ST_WAITK, ST_CMP, ST_OUT
	} mva_state_t;

	typedef struct packed {
		logic ld_i;
		logic ld_j;
		logic cord_start;
		logic dir_wr;
		logic ld_dj;
		logic cmp;
		logic clr_best;
	} mva_cmd_t;

	typedef struct packed {
		logic cord_done;
		logic dj_ok;
		logic dk_ok;
	} mva_sts_t;

	function automatic logic [DirW-1:0] atan_turns(input logic [4:0] s);
		logic [DirW-1:0] r;
		case (s)
			5'd0: r = 32'h20000000; 5'd1: r = 32'h12E4051E;
			5'd2: r = 32'h09FB385B; 5'd3: r = 32'h051111D4;
			5'd4: r = 32'h028B0D43; 5'd5: r = 32'h0145D7E1;
			5'd6: r = 32'h00A2F61E; 5'd7: r = 32'h00517C55;
			5'd8: r = 32'h0028BE53; 5'd9: r = 32'h00145F2F;
			5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2FA; 5'd15: r = 32'h0000517D;
			5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518;
			5'd20: r = 32'h0000028C; 5'd21: r = 32'h00000146;
			5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
			5'd24: r = 32'h00000029; 5'd25: r = 32'h00000014;
			5'd26: r = 32'h0000000A; 5'd27: r = 32'h00000005;
			5'd28: r = 32'h00000003; 5'd29: r = 32'h00000001;
			5'd30: r = 32'h00000001; default: r = 32'h00000000;
		endcase
		return r;
	endfunction
endpackage
`default_nettype wire

// File: rtl/mva_ram.sv
// ----------------------------------------------------------------------------
// mva_ram
// Generic single-port write, single-port read RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module mva_ram #(
	parameter int Width = 24,
	parameter int Depth = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// File: rtl/mva_cordic.sv
// ----------------------------------------------------------------------------
// mva_cordic
// Iterative vectoring CORDIC, one step per cycle, returns direction in turns.
// ----------------------------------------------------------------------------
`default_nettype none
module mva_cordic import mva_pkg::*; #(
	parameter int CordicSteps = 20
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic signed [CoordW:0]   dx,
	input  wire logic signed [CoordW:0]   dy,
	output logic                          done,
	output logic             [DirW-1:0]   dir
);
	localparam int Steps = (CordicSteps > 32) ? 32 : CordicSteps;

	logic signed [CordW-1:0] x_q, y_q, xs, ys;
	logic [DirW-1:0] z_q;
	logic [5:0] s_q;
	logic busy_q;

	assign xs = x_q >>> s_q;
	assign ys = y_q >>> s_q;
	assign dir = z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			s_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				s_q <= '0;
			end else if (busy_q) begin
				if (s_q == 6'(Steps - 1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
				s_q <= s_q + 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			if (dx < 0) begin
				x_q <= -({{(CordW-CoordW-33){dx[CoordW]}}, dx, 32'd0});
				y_q <= -({{(CordW-CoordW-33){dy[CoordW]}}, dy, 32'd0});
				z_q <= 32'h80000000;
			end else begin
				x_q <= {{(CordW-CoordW-33){dx[CoordW]}}, dx, 32'd0};
				y_q <= {{(CordW-CoordW-33){dy[CoordW]}}, dy, 32'd0};
				z_q <= '0;
			end
		end else if (busy_q) begin
			if (y_q > 0) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atan_turns(s_q[4:0]);
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atan_turns(s_q[4:0]);
			end
		end
	end
endmodule
`default_nettype wire

// File: rtl/mva_datapath.sv
// ----------------------------------------------------------------------------
// mva_datapath
// Point stores, direction table, CORDIC and running maximum.
// ----------------------------------------------------------------------------
`default_nettype none
module mva_datapath import mva_pkg::*; #(
	parameter int MaxPoints = 64,
	parameter int CordicSteps = 20
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           pt_we,
	input  wire logic [$clog2(MaxPoints)-1:0]   pt_waddr,
	input  wire mva_in_t                        pt_in,
	input  wire logic [$clog2(MaxPoints)-1:0]   pt_raddr,
	input  wire logic [$clog2(MaxPoints)-1:0]   dir_addr,
	input  wire logic                           idx_eq,
	input  wire mva_cmd_t                       cmd,
	output mva_sts_t                            sts,
	output logic [AngW-1:0]                     best
);
	logic signed [CoordW-1:0] rx, ry, xi_q, yi_q;
	logic signed [CoordW:0] dx_q, dy_q;
	logic [DirW:0] dir_rd;
	logic [DirW-1:0] cdir, dj_q, d, fd;
	logic cdone, jok_q, djok_q;
	logic [DirW+7:0] prod_s1;
	logic [DirW+7:0] deg;
	logic [AngW-1:0] best_q;

	mva_ram #(.Width(CoordW), .Depth(MaxPoints)) u_xram (
		.clk(clk), .we(pt_we), .waddr(pt_waddr), .wdata(pt_in.coord_x),
		.raddr(pt_raddr), .rdata(rx)
	);
	mva_ram #(.Width(CoordW), .Depth(MaxPoints)) u_yram (
		.clk(clk), .we(pt_we), .waddr(pt_waddr), .wdata(pt_in.coord_y),
		.raddr(pt_raddr), .rdata(ry)
	);
	mva_ram #(.Width(DirW+1), .Depth(MaxPoints)) u_dram (
		.clk(clk), .we(cmd.dir_wr), .waddr(dir_addr), .wdata({jok_q, cdir}),
		.raddr(dir_addr), .rdata(dir_rd)
	);

	mva_cordic #(.CordicSteps(CordicSteps)) u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cmd.cord_start),
		.dx(dx_q), .dy(dy_q), .done(cdone), .dir(cdir)
	);

	always_ff @(posedge clk) begin
		if (cmd.ld_i) begin
			xi_q <= rx;
			yi_q <= ry;
		end
		if (cmd.ld_j) begin
			dx_q <= {rx[CoordW-1], rx} - {xi_q[CoordW-1], xi_q};
			dy_q <= {ry[CoordW-1], ry} - {yi_q[CoordW-1], yi_q};
			jok_q <= !idx_eq && (rx != xi_q || ry != yi_q);
		end
		if (cmd.ld_dj) begin
			dj_q <= dir_rd[DirW-1:0];
			djok_q <= dir_rd[DirW];
		end
		prod_s1 <= 40'(fd) * 40'd180;
	end

	assign d = dj_q - dir_rd[DirW-1:0];
	assign fd = (d > 32'h80000000) ? (32'd0 - d) : d;
	assign deg = (prod_s1 + 40'h4000) >> 15;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q <= '0;
		end else if (cmd.clr_best) begin
			best_q <= '0;
		end else if (cmd.cmp && deg > 40'(best_q)) begin
			best_q <= deg[AngW-1:0];
		end
	end

	assign best = best_q;
	assign sts.cord_done = cdone;
	assign sts.dj_ok = djok_q;
	assign sts.dk_ok = dir_rd[DirW];
endmodule
`default_nettype wire

// File: rtl/mva_ctrl.sv
// ----------------------------------------------------------------------------
// mva_ctrl
// Sequencer for load, per-vertex direction pass and pair scan.
// ----------------------------------------------------------------------------
`default_nettype none
module mva_ctrl import mva_pkg::*; #(
	parameter int MaxPoints = 64
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	input  wire mva_in_t                      in_data,
	output logic                              in_stall,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic                              dropped,
	output logic                              pt_we,
	output logic [$clog2(MaxPoints)-1:0]      pt_waddr,
	output logic [$clog2(MaxPoints)-1:0]      pt_raddr,
	output logic [$clog2(MaxPoints)-1:0]      dir_addr,
	output logic                              idx_eq,
	output mva_cmd_t                          cmd,
	input  wire mva_sts_t                     sts
);
	localparam int AW = $clog2(MaxPoints);
	localparam int CW = $clog2(MaxPoints + 1);

	mva_state_t st_q, st_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [AW-1:0] i_q, j_q, k_q, i_d, j_d, k_d;
	logic ovf_q, ovf_d, ov_q, ov_d, cmpv_q, acc;
	logic last_i, last_j, last_k;

	assign acc = in_valid && !in_stall;
	assign last_i = (CW'(i_q) == cnt_q - CW'(1));
	assign last_j = (CW'(j_q) == cnt_q - CW'(1));
	assign last_k = (CW'(k_q) == cnt_q - CW'(1));
	assign pt_we = acc && cnt_q != CW'(MaxPoints);
	assign pt_waddr = cnt_q[AW-1:0];
	assign idx_eq = (i_q == j_q);
	assign out_valid = (st_q == ST_OUT);
	assign dropped = ov_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_LOAD;
			cnt_q <= '0;
			ovf_q <= 1'b0;
			ov_q <= 1'b0;
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
			cmpv_q <= 1'b0;
		end else begin
			st_q <= st_d;
			cnt_q <= cnt_d;
			ovf_q <= ovf_d;
			ov_q <= ov_d;
			i_q <= i_d;
			j_q <= j_d;
			k_q <= k_d;
			cmpv_q <= (st_q == ST_WAITK) && sts.dj_ok && sts.dk_ok && (k_q != j_q);
		end
	end

	always_comb begin
		st_d = st_q;
		cnt_d = cnt_q;
		ovf_d = ovf_q;
		ov_d = ov_q;
		i_d = i_q;
		j_d = j_q;
		k_d = k_q;
		in_stall = 1'b1;
		pt_raddr = i_q;
		dir_addr = j_q;
		cmd = '0;
		cmd.cmp = cmpv_q;
		unique case (st_q)
			ST_LOAD: begin
				in_stall = 1'b0;
				if (acc) begin
					if (cnt_q != CW'(MaxPoints)) cnt_d = cnt_q + CW'(1);
					else ovf_d = 1'b1;
					if (in_data.is_last) begin
						cmd.clr_best = 1'b1;
						ov_d = ovf_d;
						i_d = '0;
						if (cnt_d >= CW'(3)) st_d = ST_RDI;
						else st_d = ST_OUT;
					end
				end
			end
			ST_RDI: begin
				pt_raddr = i_q;
				st_d = ST_WAITI;
			end
			ST_WAITI: begin
				cmd.ld_i = 1'b1;
				j_d = '0;
				st_d = ST_RDJ;
			end
			ST_RDJ: begin
				pt_raddr = j_q;
				st_d = ST_WAITJ;
			end
			ST_WAITJ: begin
				cmd.ld_j = 1'b1;
				st_d = ST_CSTART;
			end
			ST_CSTART: begin
				cmd.cord_start = 1'b1;
				st_d = ST_CORD;
			end
			ST_CORD: begin
				st_d = ST_CORD;
				if (sts.cord_done) begin
					cmd.dir_wr = 1'b1;
					if (last_j) begin
						j_d = '0;
						st_d = ST_RDJ2;
					end else begin
						j_d = j_q + AW'(1);
						st_d = ST_RDJ;
					end
				end
			end
			ST_RDJ2: begin
				dir_addr = j_q;
				k_d = '0;
				st_d = ST_RDK;
			end
			ST_RDK: begin
				cmd.ld_dj = 1'b1;
				dir_addr = k_q;
				st_d = ST_WAITK;
			end
			ST_WAITK: begin
				dir_addr = k_q + AW'(1);
				if (!sts.dj_ok || last_k) begin
					if (last_j) begin
						st_d = ST_CMP;
					end else begin
						j_d = j_q + AW'(1);
						st_d = ST_RDJ2;
					end
				end else begin
					k_d = k_q + AW'(1);
					st_d = ST_WAITK;
				end
			end
			ST_CMP: begin
				if (!cmpv_q) begin
					if (last_i) begin
						st_d = ST_OUT;
					end else begin
						i_d = i_q + AW'(1);
						st_d = ST_RDI;
					end
				end
			end
			ST_OUT: begin
				if (!out_stall) begin
					cnt_d = '0;
					ovf_d = 1'b0;
					st_d = ST_LOAD;
				end
			end
			default: st_d = ST_LOAD;
		endcase
	end
endmodule
`default_nettype wire

// File: rtl/max_vertex_angle_point_set_top.sv
// ----------------------------------------------------------------------------
// max_vertex_angle_point_set_top
// Largest vertex angle of a loaded point set via iterative CORDIC.
// ----------------------------------------------------------------------------
// channel   dir   handshake             payload
// in        in    in_valid / in_stall   mva_in_t
// out       out   out_valid / out_stall mva_out_t
// Points load one per cycle. After the last point, the search runs one
// CORDIC pass per direction on the single shared CORDIC, then one direction
// RAM read per pair.
// Input stalls from the last point until the transaction leaves.
// Reset clears counters and control; the stores need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none
module max_vertex_angle_point_set_top import mva_pkg::*; #(
	parameter int MAX_POINTS = 64,
	parameter int CORDIC_STEPS = 20
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_stall,
	input  wire mva_in_t  in_data,
	output logic          out_valid,
	input  wire logic     out_stall,
	output mva_out_t      out_data
);
	localparam int AW = $clog2(MAX_POINTS);

	logic pt_we, idx_eq, dropped;
	logic [AW-1:0] pt_waddr, pt_raddr, dir_addr;
	mva_cmd_t cmd;
	mva_sts_t sts;
	logic [AngW-1:0] best;

	mva_ctrl #(.MaxPoints(MAX_POINTS)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_data(in_data),
		.in_stall(in_stall), .out_valid(out_valid), .out_stall(out_stall),
		.dropped(dropped), .pt_we(pt_we), .pt_waddr(pt_waddr),
		.pt_raddr(pt_raddr), .dir_addr(dir_addr), .idx_eq(idx_eq),
		.cmd(cmd), .sts(sts)
	);

	mva_datapath #(.MaxPoints(MAX_POINTS), .CordicSteps(CORDIC_STEPS)) u_dp (
		.clk(clk), .arst_n(arst_n), .pt_we(pt_we), .pt_waddr(pt_waddr),
		.pt_in(in_data), .pt_raddr(pt_raddr), .dir_addr(dir_addr),
		.idx_eq(idx_eq), .cmd(cmd), .sts(sts), .best(best)
	);

	assign out_data.max_angle = best;
	assign out_data.points_dropped = dropped;
endmodule
`default_nettype wire

// File: rtl/mva_checker.sv
// ----------------------------------------------------------------------------
// mva_checker
// Port-level checks on the max vertex angle block.
// ----------------------------------------------------------------------------
`default_nettype none
module mva_checker import mva_pkg::*; (
	input wire logic     clk,
	input wire logic     arst_n,
	input wire logic     in_valid,
	input wire logic     in_stall,
	input wire mva_in_t  in_data,
	input wire logic     out_valid,
	input wire logic     out_stall,
	input wire mva_out_t out_data
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("output transaction changed while stalled");
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.max_angle <= 24'd11796480)
		else $error("angle above 180 degrees");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input open while result pending");
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.is_last |=> in_stall)
		else $error("input open after last point");
endmodule

bind max_vertex_angle_point_set_top mva_checker u_mva_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
	.out_data(out_data)
);
`default_nettype wire
